### src/hbe_pkg.sv
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared types and constants of the huffman bit encoder.
// ----------------------------------------------------------------------------
package hbe_pkg;

  localparam int unsigned MaxCodeLenC  = 64;
  localparam int unsigned NumSymbolsC  = 256;
  localparam int unsigned QueueDepthC  = 2;

  localparam int unsigned OpW          = 2;
  localparam int unsigned SymbolW      = 8;
  localparam int unsigned CodeValueW   = 64;
  localparam int unsigned CodeLengthW  = 7;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned PadW         = 3;
  localparam int unsigned PendW        = 3;
  localparam int unsigned NeedW        = 4;

  typedef enum logic [OpW-1:0] {
    OpLoad   = 2'd0,
    OpEncode = 2'd1,
    OpFlush  = 2'd2
  } hbe_op_e;

  // back end status seen by the top level checks
  typedef struct packed {
    logic             busy;
    logic [PendW-1:0] pend_cnt;
  } hbe_back_status_t;

endpackage

### src/hbe_in_if.sv
// ----------------------------------------------------------------------------
// hbe_in_if
// Input channel: command, symbol and code table entry.
// ----------------------------------------------------------------------------
interface hbe_in_if;
  import hbe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic [SymbolW-1:0]     symbol;
  logic [CodeValueW-1:0]  code_value;
  logic [CodeLengthW-1:0] code_length;

  modport source (output valid, op, symbol, code_value, code_length, input ready);
  modport sink   (input valid, op, symbol, code_value, code_length, output ready);
endinterface

### src/hbe_out_if.sv
// ----------------------------------------------------------------------------
// hbe_out_if
// Output channel: packed bytes and flush results.
// ----------------------------------------------------------------------------
interface hbe_out_if;
  import hbe_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packed_byte;
  logic             byte_valid;
  logic [PadW-1:0]  pad_bits;
  logic             last;

  modport source (output valid, packed_byte, byte_valid, pad_bits, last, input ready);
  modport sink   (input valid, packed_byte, byte_valid, pad_bits, last, output ready);
endinterface

### src/hbe_ram.sv
// ----------------------------------------------------------------------------
// hbe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/hbe_front.sv
// ----------------------------------------------------------------------------
// hbe_front
// Accepts items, keeps the code table and hands aligned codes to the queue.
// ----------------------------------------------------------------------------
module hbe_front #(
  parameter int unsigned MAX_CODE_LEN = hbe_pkg::MaxCodeLenC,
  parameter int unsigned NUM_SYMBOLS  = hbe_pkg::NumSymbolsC,
  parameter int unsigned LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  hbe_in_if.sink                  in_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_o_i,
  output logic                    push_flush_o,
  output logic [LEN_W-1:0]        push_len_o,
  output logic [MAX_CODE_LEN-1:0] push_work_o
);
  import hbe_pkg::*;

  localparam int unsigned SymIdxW = $clog2(NUM_SYMBOLS);
  localparam int unsigned EntryW  = LEN_W + MAX_CODE_LEN;

  logic                   accept;
  logic                   sym_ok;
  logic                   is_load;
  logic                   is_encode;
  logic                   is_flush;
  logic [SymIdxW-1:0]     sym_idx;
  logic [LEN_W-1:0]       len_sat;
  logic [EntryW-1:0]      rdata;
  logic [LEN_W-1:0]       rd_len;

  logic [NUM_SYMBOLS-1:0] valid_q, valid_d;
  logic                   s1_valid_q, s1_valid_d;
  logic                   s1_flush_q;
  logic                   s1_hit_q;

  assign sym_idx   = in_i.symbol[SymIdxW-1:0];
  assign sym_ok    = ({1'b0, in_i.symbol} < (SymbolW+1)'(NUM_SYMBOLS));
  assign is_load   = (in_i.op == OpLoad) && sym_ok;
  assign is_encode = (in_i.op == OpEncode) && sym_ok;
  assign is_flush  = (in_i.op == OpFlush);
  assign in_i.ready = !s1_valid_q || push_ready_o_i;
  assign accept    = in_i.valid && in_i.ready;

  assign len_sat = (in_i.code_length > CodeLengthW'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : in_i.code_length[LEN_W-1:0];

  hbe_ram #(
    .WIDTH (EntryW),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (sym_idx),
    .wdata_i ({len_sat, in_i.code_value[MAX_CODE_LEN-1:0]}),
    .re_i    (accept && is_encode),
    .raddr_i (sym_idx),
    .rdata_o (rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (accept && is_load) begin
      valid_d[sym_idx] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push_valid_o && push_ready_o_i) begin
      s1_valid_d = 1'b0;
    end
    if (accept && (is_encode || is_flush)) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q <= is_flush;
      s1_hit_q   <= valid_q[sym_idx];
    end
  end

  // unwritten entries and flushes carry no code bits
  assign rd_len = (s1_hit_q && !s1_flush_q) ? rdata[EntryW-1 -: LEN_W] : '0;

  // first code bit goes to the top of the work word
  assign push_valid_o = s1_valid_q;
  assign push_flush_o = s1_flush_q;
  assign push_len_o   = rd_len;
  assign push_work_o  = rdata[MAX_CODE_LEN-1:0] << (LEN_W'(MAX_CODE_LEN) - rd_len);

endmodule

### src/hbe_queue.sv
// ----------------------------------------------------------------------------
// hbe_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module hbe_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = hbe_pkg::QueueDepthC
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/hbe_back.sv
// ----------------------------------------------------------------------------
// hbe_back
// Packs code bits into bytes, one completed byte per cycle while the output slot is free, and flushes.
// ----------------------------------------------------------------------------
module hbe_back #(
  parameter int unsigned MAX_CODE_LEN = hbe_pkg::MaxCodeLenC,
  parameter int unsigned LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  logic                     pop_flush_i,
  input  logic [LEN_W-1:0]         pop_len_i,
  input  logic [MAX_CODE_LEN-1:0]  pop_work_i,
  hbe_out_if.source                out_o,
  output hbe_pkg::hbe_back_status_t status_o
);
  import hbe_pkg::*;

  logic                    cur_valid_q, cur_valid_d;
  logic                    cur_flush_q;
  logic [LEN_W-1:0]        rem_q, rem_d;
  logic [MAX_CODE_LEN-1:0] work_q, work_d;
  logic [PendW-1:0]        cnt_q, cnt_d;
  logic [PendW+3:0]        acc_q, acc_d;

  logic                    out_valid_q, out_valid_d;
  logic [ByteW-1:0]        out_byte_q;
  logic                    out_bvalid_q;
  logic [PadW-1:0]         out_pad_q;
  logic                    out_last_q;

  logic [NeedW-1:0]        need;
  logic [ByteW-1:0]        top8, top8_next;
  logic [MAX_CODE_LEN-1:0] work_next;
  logic [LEN_W-1:0]        rem_next;
  logic [PendW-1:0]        rem_low;
  logic [ByteW+PendW+3:0]  acc_wide;
  logic                    emit, done, fire, slot_free, pop;
  logic [ByteW-1:0]        e_byte;
  logic                    e_bvalid;
  logic [PadW-1:0]         e_pad;
  logic                    e_last;
  logic [PendW-1:0]        n_cnt;
  logic [PendW+3:0]        n_acc;

  assign need      = NeedW'(8) - {1'b0, cnt_q};
  assign top8      = work_q[MAX_CODE_LEN-1 -: ByteW];
  assign work_next = work_q << need;
  assign rem_next  = rem_q - LEN_W'(need);
  assign top8_next = work_next[MAX_CODE_LEN-1 -: ByteW];
  assign rem_low   = rem_q[PendW-1:0];
  assign acc_wide  = {{ByteW{1'b0}}, acc_q} << need;

  always_comb begin
    emit     = 1'b0;
    done     = 1'b1;
    e_byte   = '0;
    e_bvalid = 1'b0;
    e_pad    = '0;
    e_last   = 1'b0;
    n_cnt    = cnt_q;
    n_acc    = acc_q;
    if (cur_flush_q) begin
      emit     = 1'b1;
      e_byte   = acc_wide[ByteW-1:0];
      e_bvalid = (cnt_q != '0);
      e_pad    = (cnt_q != '0) ? need[PadW-1:0] : '0;
      e_last   = 1'b1;
      n_cnt    = '0;
      n_acc    = '0;
    end else if (rem_q >= LEN_W'(need)) begin
      // a byte completes; leftover bits under a byte stay pending
      emit     = 1'b1;
      e_byte   = acc_wide[ByteW-1:0] | (top8 >> cnt_q);
      e_bvalid = 1'b1;
      if (rem_next < LEN_W'(8)) begin
        e_last = 1'b1;
        n_cnt  = rem_next[PendW-1:0];
        n_acc  = (PendW+4)'(top8_next >> (NeedW'(8) - {1'b0, rem_next[PendW-1:0]}));
      end else begin
        done  = 1'b0;
        n_cnt = '0;
        n_acc = '0;
      end
    end else begin
      n_cnt = cnt_q + rem_low;
      n_acc = (PendW+4)'((acc_q << rem_low) |
                         (PendW+4)'(top8 >> (NeedW'(8) - {1'b0, rem_low})));
    end
  end

  assign slot_free   = !out_valid_q || out_o.ready;
  assign fire        = cur_valid_q && (!emit || slot_free);
  assign pop_ready_o = !cur_valid_q || (fire && done);
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    cur_valid_d = cur_valid_q;
    rem_d       = rem_q;
    work_d      = work_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      cnt_d = n_cnt;
      acc_d = n_acc;
      if (emit) begin
        out_valid_d = 1'b1;
      end
      if (done) begin
        cur_valid_d = 1'b0;
      end else begin
        work_d = work_next;
        rem_d  = rem_next;
      end
    end
    if (pop) begin
      cur_valid_d = 1'b1;
      rem_d       = pop_len_i;
      work_d      = pop_work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    if (pop) begin
      cur_flush_q <= pop_flush_i;
    end
    if (fire && emit) begin
      out_byte_q   <= e_byte;
      out_bvalid_q <= e_bvalid;
      out_pad_q    <= e_pad;
      out_last_q   <= e_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_byte = out_byte_q;
  assign out_o.byte_valid  = out_bvalid_q;
  assign out_o.pad_bits    = out_pad_q;
  assign out_o.last        = out_last_q;

  assign status_o.busy     = cur_valid_q;
  assign status_o.pend_cnt = cnt_q;

endmodule

### src/huffman_bit_encoder_core.sv
// ----------------------------------------------------------------------------
// huffman_bit_encoder_core
// Table driven huffman encoder with msb-first byte packing.
//
//   channel  dir  payload                                          transfer
//   in_i     in   op, symbol, code_value, code_length              valid & ready
//   out_o    out  packed_byte, byte_valid, pad_bits, last          valid & ready
//
// One item per cycle enters while in_i.ready is high; an encode that completes n bytes
// holds the packer, which takes no new item until the last of those bytes is out.
// An input transfer reaches the output through the table read, the queue, the packer
// and the output register. A flush gives a single packer result.
// Reset clears the code length valid bits at once; no clearing pass.
// Output stalls back up through the packer and queue to in_i.ready.
// ----------------------------------------------------------------------------
module huffman_bit_encoder_core #(
  parameter int unsigned MAX_CODE_LEN = hbe_pkg::MaxCodeLenC,
  parameter int unsigned NUM_SYMBOLS  = hbe_pkg::NumSymbolsC
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbe_in_if.sink     in_i,
  hbe_out_if.source  out_o
);
  import hbe_pkg::*;

  localparam int unsigned LenW   = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned QDataW = 1 + LenW + MAX_CODE_LEN;

  logic                    push_valid, push_ready;
  logic                    push_flush;
  logic [LenW-1:0]         push_len;
  logic [MAX_CODE_LEN-1:0] push_work;
  logic                    pop_valid, pop_ready;
  logic [QDataW-1:0]       pop_data;
  hbe_back_status_t        back_status;

  hbe_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .LEN_W        (LenW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .push_valid_o   (push_valid),
    .push_ready_o_i (push_ready),
    .push_flush_o   (push_flush),
    .push_len_o     (push_len),
    .push_work_o    (push_work)
  );

  hbe_queue #(
    .WIDTH (QDataW),
    .DEPTH (QueueDepthC)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_flush, push_len, push_work}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  hbe_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .LEN_W        (LenW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_flush_i (pop_data[QDataW-1]),
    .pop_len_i   (pop_data[QDataW-2 -: LenW]),
    .pop_work_i  (pop_data[MAX_CODE_LEN-1:0]),
    .out_o       (out_o),
    .status_o    (back_status)
  );

`ifndef NO_ASSERTIONS
  // an empty flush result carries nothing else
  a_empty_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.byte_valid |->
      out_o.last && out_o.pad_bits == '0 && out_o.packed_byte == '0)
    else $error("empty result with data");

  // padding only comes with a flushed byte, which always ends its item
  a_pad_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.pad_bits != '0 |-> out_o.last && out_o.byte_valid)
    else $error("padding on a non-final result");

  // a flush that the packer completes leaves nothing pending
  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) && out_o.pad_bits != '0 |-> back_status.pend_cnt == '0)
    else $error("pending bits survive a flush");

  // a byte that does not end its item leaves the rest of the code in the packer
  a_mid_code_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> back_status.busy)
    else $error("packer idle in the middle of a code");
`endif

endmodule
